[hw/rtl/eq_pkg.sv]
// Shared types, constants and helper functions for the Euler-to-quaternion pipeline.
// Depends on nothing; used by euler_to_quaternion.
package eq_pkg;

   localparam int ANGLE_W           = 17;
   localparam int QUAT_W            = 16;
   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int TRIG_STAGES_DEF   = 16;
   localparam int MAX_TRIG_STAGES   = 32;
   localparam int WORK_FRAC         = 30;
   localparam int DEG_HALF_TURN     = 180;
   localparam int ANGLE_LIMIT       = 46080;
   localparam int RECIP_SHIFT       = 24;
   // ceil(2^24 / 180); exact quotient for every magnitude up to the angle limit.
   localparam logic [16:0] RECIP_180 = 17'd93207;
   localparam int LUT_DEPTH         = 180;

   typedef logic signed [35:0] xy_type;
   typedef logic signed [32:0] ang_type;
   typedef logic signed [31:0] trig_type;
   typedef logic [22:0] frac_lut_type [LUT_DEPTH];

   localparam xy_type  CORDIC_GAIN  = 36'sh09B74EDA8;
   localparam ang_type QUARTER_TURN = 33'sh040000000;
   localparam ang_type HALF_TURN    = 33'sh080000000;

   localparam logic [31:0] ATAN_UNITS [MAX_TRIG_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // Binary-angle units of a remainder r (degrees, 7 fraction bits) below 180,
   // rounded to nearest. Evaluated at elaboration only.
   function automatic frac_lut_type build_frac_lut();
      frac_lut_type lut;
      longint       num;
      for (int r = 0; r < LUT_DEPTH; r++) begin
         num    = (longint'(r) << 23) + longint'(DEG_HALF_TURN / 2);
         lut[r] = 23'(num / DEG_HALF_TURN);
      end
      return lut;
   endfunction

   localparam frac_lut_type FRAC_LUT = build_frac_lut();

   // Q32 to Q30, half away from zero.
   function automatic trig_type round_q32(xy_type v);
      xy_type m;
      m = (v < 0) ? -v : v;
      m = (m + 36'sd2) >>> 2;
      return (v < 0) ? -m[31:0] : m[31:0];
   endfunction

   // Q30 product, rounded back to Q30 half away from zero.
   function automatic trig_type mulq(trig_type a, trig_type b);
      logic signed [63:0] p;
      logic [63:0]        m;
      p = a * b;
      m = (p < 0) ? 64'(-p) : 64'(p);
      m = (m + (64'd1 << 29)) >> 30;
      return (p < 0) ? -m[31:0] : m[31:0];
   endfunction

endpackage

[hw/rtl/euler_to_quaternion.sv]
// Top level: yaw/pitch/roll in degrees to the Z-Y-X unit quaternion, fully pipelined.
// Depends on eq_pkg for types, the atan and remainder tables and rounding helpers.
//
// Usage:
//   Input channel req_valid/req_ready carries one transaction of three signed angles
//   (degrees, 7 fraction bits); inputs beyond +-360 degrees are clamped.
//   Output channel rsp_valid/rsp_ready carries quat_w/x/y/z, signed with OUT_FRAC_BITS
//   fraction bits, rounded and saturated to +-1.0.
//   The stages, in order, are angle scaling, the CORDIC rotations (16 CORDIC stages by
//   default), a rounding stage, the product stages and the output register.
//   Throughput is one transaction per cycle unless rsp_ready stalls; the three CORDIC lanes
//   and the twelve product multipliers are all dedicated, so nothing is shared between items.
//   Every stage has its own valid bit and loads whenever it is empty or the next one
//   moves, so a stalled receiver freezes only the full stages behind the output and
//   empty slots keep accepting new transactions until the pipeline is full.
//   Reset clears all valid bits; the data registers are not reset.
module euler_to_quaternion #(
   parameter int OUT_FRAC_BITS = eq_pkg::OUT_FRAC_BITS_DEF,
   parameter int TRIG_STAGES   = eq_pkg::TRIG_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [eq_pkg::ANGLE_W-1:0]   req_yaw_deg,
   input  logic signed [eq_pkg::ANGLE_W-1:0]   req_pitch_deg,
   input  logic signed [eq_pkg::ANGLE_W-1:0]   req_roll_deg,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [eq_pkg::QUAT_W-1:0]    rsp_quat_w,
   output logic signed [eq_pkg::QUAT_W-1:0]    rsp_quat_x,
   output logic signed [eq_pkg::QUAT_W-1:0]    rsp_quat_y,
   output logic signed [eq_pkg::QUAT_W-1:0]    rsp_quat_z
);
   import eq_pkg::*;

   localparam int NSTG     = (TRIG_STAGES > MAX_TRIG_STAGES) ? MAX_TRIG_STAGES : TRIG_STAGES;
   localparam int NPIPE    = NSTG + 7;
   localparam int ST_ROUND = NSTG + 3;
   localparam int ST_P1    = NSTG + 4;
   localparam int ST_P2    = NSTG + 5;
   localparam int ST_OUT   = NSTG + 6;
   localparam int OUT_SH   = WORK_FRAC - OUT_FRAC_BITS;
   localparam int HALF_SH  = (OUT_SH > 0) ? OUT_SH - 1 : 0;
   localparam logic [33:0] OUT_HALF = (OUT_SH > 0) ? (34'd1 << HALF_SH) : 34'd0;
   localparam logic signed [33:0] OUT_ONE = 34'sd1 <<< OUT_FRAC_BITS;

   // ---------------------------------------------------------------- flow control
   logic [NPIPE-1:0] vld_ff;
   logic [NPIPE-1:0] en;

   always_comb begin
      en[NPIPE-1] = !vld_ff[NPIPE-1] || rsp_ready;
      for (int k = NPIPE - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NPIPE; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? req_valid : vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NPIPE-1];

   // ---------------------------------------------------------------- stage 0: clamp, magnitude
   logic signed [ANGLE_W-1:0] ang_in [3];
   logic [15:0]               s0_mag_in [3];
   logic                      s0_neg_in [3];
   logic [15:0]               s0_mag_ff [3];
   logic                      s0_neg_ff [3];
   logic signed [ANGLE_W-1:0] clamped;

   assign ang_in[0] = req_yaw_deg;
   assign ang_in[1] = req_pitch_deg;
   assign ang_in[2] = req_roll_deg;

   always_comb begin
      clamped = '0;
      for (int l = 0; l < 3; l++) begin
         if (ang_in[l] > 17'(ANGLE_LIMIT)) begin
            clamped = 17'(ANGLE_LIMIT);
         end else if (ang_in[l] < -17'(ANGLE_LIMIT)) begin
            clamped = -17'(ANGLE_LIMIT);
         end else begin
            clamped = ang_in[l];
         end
         s0_neg_in[l] = clamped[ANGLE_W-1];
         s0_mag_in[l] = clamped[ANGLE_W-1] ? 16'(-clamped) : clamped[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_mag_ff <= s0_mag_in;
         s0_neg_ff <= s0_neg_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: quotient by 180
   logic [32:0] recip_prod [3];
   logic [8:0]  s1_q_ff    [3];
   logic [15:0] s1_mag_ff  [3];
   logic        s1_neg_ff  [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         recip_prod[l] = {17'd0, s0_mag_ff[l]} * {16'd0, RECIP_180};
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int l = 0; l < 3; l++) begin
            s1_q_ff[l] <= recip_prod[l][32:RECIP_SHIFT];
         end
         s1_mag_ff <= s0_mag_ff;
         s1_neg_ff <= s0_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2: binary angle, fold
   logic [15:0] q_times;
   logic [7:0]  rem;
   logic [31:0] a_mag;
   ang_type     a_sgn;
   ang_type     s2_z_in    [3];
   logic        s2_flip_in [3];
   ang_type     s2_z_ff    [3];
   logic        s2_flip_ff [3];

   always_comb begin
      q_times = '0;
      rem     = '0;
      a_mag   = '0;
      a_sgn   = '0;
      for (int l = 0; l < 3; l++) begin
         q_times = 16'({7'd0, s1_q_ff[l]} * 16'd180);
         rem     = 8'(s1_mag_ff[l] - q_times);
         a_mag   = {s1_q_ff[l], 23'd0} + {9'd0, FRAC_LUT[rem]};
         a_sgn   = s1_neg_ff[l] ? -ang_type'({1'b0, a_mag}) : ang_type'({1'b0, a_mag});
         // Half angles past a quarter turn move by half a turn; cos and sin flip sign.
         if (a_sgn > QUARTER_TURN) begin
            s2_z_in[l]    = a_sgn - HALF_TURN;
            s2_flip_in[l] = 1'b1;
         end else if (a_sgn < -QUARTER_TURN) begin
            s2_z_in[l]    = a_sgn + HALF_TURN;
            s2_flip_in[l] = 1'b1;
         end else begin
            s2_z_in[l]    = a_sgn;
            s2_flip_in[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_z_ff    <= s2_z_in;
         s2_flip_ff <= s2_flip_in;
      end
   end

   // ---------------------------------------------------------------- CORDIC rotations
   xy_type  cx_ff    [NSTG][3];
   xy_type  cy_ff    [NSTG][3];
   ang_type cz_ff    [NSTG][3];
   logic    cflip_ff [NSTG][3];

   for (genvar i = 0; i < NSTG; i++) begin : g_cordic
      localparam ang_type STEP = ang_type'({1'b0, ATAN_UNITS[i]});
      xy_type  x_i [3];
      xy_type  y_i [3];
      ang_type z_i [3];
      logic    f_i [3];

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (i == 0) begin
               x_i[l] = CORDIC_GAIN;
               y_i[l] = '0;
               z_i[l] = s2_z_ff[l];
               f_i[l] = s2_flip_ff[l];
            end else begin
               x_i[l] = cx_ff[(i == 0) ? 0 : i-1][l];
               y_i[l] = cy_ff[(i == 0) ? 0 : i-1][l];
               z_i[l] = cz_ff[(i == 0) ? 0 : i-1][l];
               f_i[l] = cflip_ff[(i == 0) ? 0 : i-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[3+i]) begin
            for (int l = 0; l < 3; l++) begin
               if (z_i[l] >= 0) begin
                  cx_ff[i][l] <= x_i[l] - (y_i[l] >>> i);
                  cy_ff[i][l] <= y_i[l] + (x_i[l] >>> i);
                  cz_ff[i][l] <= z_i[l] - STEP;
               end else begin
                  cx_ff[i][l] <= x_i[l] + (y_i[l] >>> i);
                  cy_ff[i][l] <= y_i[l] - (x_i[l] >>> i);
                  cz_ff[i][l] <= z_i[l] + STEP;
               end
               cflip_ff[i][l] <= f_i[l];
            end
         end
      end
   end

   // ---------------------------------------------------------------- round to Q30, apply flip
   trig_type rc_ff [3];
   trig_type rs_ff [3];

   always_ff @(posedge clock) begin
      if (en[ST_ROUND]) begin
         for (int l = 0; l < 3; l++) begin
            if (cflip_ff[NSTG-1][l]) begin
               rc_ff[l] <= -round_q32(cx_ff[NSTG-1][l]);
               rs_ff[l] <= -round_q32(cy_ff[NSTG-1][l]);
            end else begin
               rc_ff[l] <= round_q32(cx_ff[NSTG-1][l]);
               rs_ff[l] <= round_q32(cy_ff[NSTG-1][l]);
            end
         end
      end
   end

   // ---------------------------------------------------------------- roll-pitch products
   // Lane 0 is yaw, lane 1 pitch, lane 2 roll.
   trig_type crcp_ff, srsp_ff, srcp_ff, crsp_ff, cy_yaw_ff, sy_yaw_ff;

   always_ff @(posedge clock) begin
      if (en[ST_P1]) begin
         crcp_ff   <= mulq(rc_ff[2], rc_ff[1]);
         srsp_ff   <= mulq(rs_ff[2], rs_ff[1]);
         srcp_ff   <= mulq(rs_ff[2], rc_ff[1]);
         crsp_ff   <= mulq(rc_ff[2], rs_ff[1]);
         cy_yaw_ff <= rc_ff[0];
         sy_yaw_ff <= rs_ff[0];
      end
   end

   // ---------------------------------------------------------------- yaw products
   trig_type m_ff [8];

   always_ff @(posedge clock) begin
      if (en[ST_P2]) begin
         m_ff[0] <= mulq(crcp_ff, cy_yaw_ff);
         m_ff[1] <= mulq(srsp_ff, sy_yaw_ff);
         m_ff[2] <= mulq(srcp_ff, cy_yaw_ff);
         m_ff[3] <= mulq(crsp_ff, sy_yaw_ff);
         m_ff[4] <= mulq(crsp_ff, cy_yaw_ff);
         m_ff[5] <= mulq(srcp_ff, sy_yaw_ff);
         m_ff[6] <= mulq(crcp_ff, sy_yaw_ff);
         m_ff[7] <= mulq(srsp_ff, cy_yaw_ff);
      end
   end

   // ---------------------------------------------------------------- sums, round, saturate
   logic signed [32:0]       sum_q  [4];
   logic [33:0]              sum_mag;
   logic signed [33:0]       sum_rnd;
   logic signed [QUAT_W-1:0] quat_in [4];
   logic signed [QUAT_W-1:0] quat_ff [4];

   always_comb begin
      sum_q[0] = 33'(m_ff[0]) + 33'(m_ff[1]);
      sum_q[1] = 33'(m_ff[2]) - 33'(m_ff[3]);
      sum_q[2] = 33'(m_ff[4]) + 33'(m_ff[5]);
      sum_q[3] = 33'(m_ff[6]) - 33'(m_ff[7]);
      sum_mag  = '0;
      sum_rnd  = '0;
      for (int c = 0; c < 4; c++) begin
         sum_mag = sum_q[c][32] ? 34'(-34'(sum_q[c])) : 34'(sum_q[c]);
         sum_mag = (sum_mag + OUT_HALF) >> OUT_SH;
         sum_rnd = sum_q[c][32] ? -$signed(sum_mag) : $signed(sum_mag);
         if (sum_rnd > OUT_ONE) begin
            sum_rnd = OUT_ONE;
         end else if (sum_rnd < -OUT_ONE) begin
            sum_rnd = -OUT_ONE;
         end
         quat_in[c] = sum_rnd[QUAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         quat_ff <= quat_in;
      end
   end

   assign rsp_quat_w = quat_ff[0];
   assign rsp_quat_x = quat_ff[1];
   assign rsp_quat_y = quat_ff[2];
   assign rsp_quat_z = quat_ff[3];

   // ---------------------------------------------------------------- assertions
   // An empty output stage must never block the input side.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[NPIPE-1] |-> req_ready)
      else $error("input stalled while output stage empty");

   // The folded yaw and roll half angles must lie within a quarter turn before the rotations.
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (s2_z_ff[0] <= QUARTER_TURN && s2_z_ff[0] >= -QUARTER_TURN &&
                     s2_z_ff[2] <= QUARTER_TURN && s2_z_ff[2] >= -QUARTER_TURN))
      else $error("half angle outside quarter turn after fold");

   // A stage holding an item while its successor is blocked must not advance.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_P2] && !en[ST_OUT]) |=> vld_ff[ST_P2] && $stable(m_ff[0]))
      else $error("product stage lost data during stall");

endmodule
